// ===== hdl/deq_pkg.sv =====
package deq_pkg;

    localparam int DW = 32;
    localparam int SW = 2;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_LIST_FWD   = 3'd4,
        OP_LIST_BWD   = 3'd5
    } op_t;

    localparam logic [SW-1:0] ST_OK    = 2'd0;
    localparam logic [SW-1:0] ST_EMPTY = 2'd1;
    localparam logic [SW-1:0] ST_FULL  = 2'd2;

    // command broadcast to every cell of the chain
    typedef enum logic [2:0] {
        CMD_HOLD       = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_PUSH_BACK  = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_POP_BACK   = 3'd4,
        CMD_ROT_FWD    = 3'd5,
        CMD_ROT_BWD    = 3'd6
    } cell_cmd_t;

    // what one cell shows its neighbors
    typedef struct packed {
        logic          valid;
        logic [DW-1:0] word;
    } link_t;

endpackage

// ===== hdl/double_ended_queue.sv =====
// Push/pop: result beat in the cycle after the request beat; one request per cycle sustained while rsp_stall stays low.
// List of n entries: first beat once the list state is registered and the output register takes it,
//   then one entry per cycle while rsp_stall allows; requests stalled until the list ends; the chain rotates per entry.
// Empty/full requests: answered like push/pop; unused codes are dropped without a beat.
// Reset (rst_n low, async) empties the chain, clears the count and the output beat.
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  logic [2:0]    op,
    input  logic [DW-1:0] value,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output logic [DW-1:0] data,
    output logic [SW-1:0] status,
    output logic          last
);

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LIST = 2'b10
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] left_reg, left_next;      // entries still to list
    logic          dir_bwd_reg, dir_bwd_next;

    // output beat register
    logic          rsp_valid_reg, rsp_valid_next;
    logic [DW-1:0] data_reg, data_next;
    logic [SW-1:0] status_reg, status_next;
    logic          last_reg, last_next;

    // cell chain
    cell_cmd_t     cmd;
    logic [DW-1:0] wrap_word;
    link_t         self_link [DEPTH];
    link_t         prev_link [DEPTH];
    link_t         next_link [DEPTH];
    logic [DW-1:0] tail_part [DEPTH];
    logic [DW-1:0] head_word;
    logic [DW-1:0] tail_word;
    logic          q_empty;
    logic          q_full;

    logic          slot_free;
    logic          accept;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            deq_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .value     (value),
                .wrap_word (wrap_word),
                .prev_link (prev_link[gi]),
                .next_link (next_link[gi]),
                .self_link (self_link[gi]),
                .tail_word (tail_part[gi])
            );
        end
    endgenerate

    // neighbor wiring: the front cell sees the incoming word on its left
    // (tail word while rotating backward), the back cell sees an empty slot
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (i == 0)
                prev_link[i] = '{valid: 1'b1,
                                 word: (cmd == CMD_ROT_BWD) ? wrap_word : value};
            else
                prev_link[i] = self_link[i-1];
            if (i == DEPTH - 1)
                next_link[i] = '{valid: 1'b0, word: '0};
            else
                next_link[i] = self_link[i+1];
        end
    end

    // at most one cell flags itself as tail, so an OR picks its word
    always_comb
    begin
        tail_word = '0;
        for (int i = 0; i < DEPTH; i++)
            tail_word = tail_word | tail_part[i];
    end

    assign head_word = self_link[0].word;
    assign q_empty   = ~self_link[0].valid;
    assign q_full    = self_link[DEPTH-1].valid;
    assign wrap_word = dir_bwd_reg ? tail_word : head_word;

    assign slot_free = ~rsp_valid_reg | ~rsp_stall;
    assign req_stall = (state_reg != S_IDLE) | ~slot_free;
    assign accept    = req_valid & ~req_stall;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        left_next      = left_reg;
        dir_bwd_next   = dir_bwd_reg;
        cmd            = CMD_HOLD;
        rsp_valid_next = rsp_valid_reg & rsp_stall;
        data_next      = data_reg;
        status_next    = status_reg;
        last_next      = last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (op_t'(op))
                        OP_PUSH_FRONT, OP_PUSH_BACK:
                        begin
                            rsp_valid_next = 1'b1;
                            data_next      = '0;
                            last_next      = 1'b1;
                            if (q_full)
                                status_next = ST_FULL;
                            else
                            begin
                                status_next = ST_OK;
                                count_next  = count_reg + 1'b1;
                                cmd = (op_t'(op) == OP_PUSH_FRONT) ? CMD_PUSH_FRONT
                                                                   : CMD_PUSH_BACK;
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK:
                        begin
                            rsp_valid_next = 1'b1;
                            last_next      = 1'b1;
                            if (q_empty)
                            begin
                                status_next = ST_EMPTY;
                                data_next   = '0;
                            end
                            else
                            begin
                                status_next = ST_OK;
                                count_next  = count_reg - 1'b1;
                                if (op_t'(op) == OP_POP_FRONT)
                                begin
                                    data_next = head_word;
                                    cmd       = CMD_POP_FRONT;
                                end
                                else
                                begin
                                    data_next = tail_word;
                                    cmd       = CMD_POP_BACK;
                                end
                            end
                        end
                        OP_LIST_FWD, OP_LIST_BWD:
                        begin
                            if (q_empty)
                            begin
                                rsp_valid_next = 1'b1;
                                data_next      = '0;
                                status_next    = ST_EMPTY;
                                last_next      = 1'b1;
                            end
                            else
                            begin
                                state_next   = S_LIST;
                                left_next    = count_reg;
                                dir_bwd_next = (op_t'(op) == OP_LIST_BWD);
                            end
                        end
                        default:
                        begin
                            // unused codes: dropped without a beat
                            cmd = CMD_HOLD;
                        end
                    endcase
                end
            end
            S_LIST:
            begin
                // one entry per free output slot; a full rotation restores order
                if (slot_free)
                begin
                    rsp_valid_next = 1'b1;
                    data_next      = wrap_word;
                    status_next    = ST_OK;
                    last_next      = (left_reg == CW'(1));
                    cmd            = dir_bwd_reg ? CMD_ROT_BWD : CMD_ROT_FWD;
                    left_next      = left_reg - 1'b1;
                    if (left_reg == CW'(1))
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            left_reg      <= '0;
            dir_bwd_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            left_reg      <= left_next;
            dir_bwd_reg   <= dir_bwd_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg   <= data_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign data      = data_reg;
    assign status    = status_reg;
    assign last      = last_reg;

endmodule

// ===== hdl/deq_cell.sv =====
module deq_cell
    import deq_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cell_cmd_t     cmd,
    input  logic [DW-1:0] value,
    input  logic [DW-1:0] wrap_word,
    input  link_t         prev_link,
    input  link_t         next_link,
    output link_t         self_link,
    output logic [DW-1:0] tail_word
);

    logic          valid_reg;
    logic          valid_next;
    logic [DW-1:0] word_reg;
    logic [DW-1:0] word_next;
    logic          is_tail;

    assign is_tail   = valid_reg & ~next_link.valid;
    assign self_link = '{valid: valid_reg, word: word_reg};
    assign tail_word = is_tail ? word_reg : '0;

    always_comb
    begin
        valid_next = valid_reg;
        word_next  = word_reg;
        unique case (cmd)
            CMD_PUSH_FRONT:
            begin
                valid_next = prev_link.valid;
                word_next  = prev_link.word;
            end
            CMD_PUSH_BACK:
            begin
                if (!valid_reg && prev_link.valid)
                begin
                    valid_next = 1'b1;
                    word_next  = value;
                end
            end
            CMD_POP_FRONT:
            begin
                valid_next = next_link.valid;
                word_next  = next_link.word;
            end
            CMD_POP_BACK:
            begin
                valid_next = valid_reg & next_link.valid;
            end
            CMD_ROT_FWD:
            begin
                if (valid_reg)
                    word_next = is_tail ? wrap_word : next_link.word;
            end
            CMD_ROT_BWD:
            begin
                if (valid_reg)
                    word_next = prev_link.word;
            end
            default:
            begin
                valid_next = valid_reg;
                word_next  = word_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

endmodule

// ===== tb/double_ended_queue_check.sv =====
`timescale 1ns / 100ps

module double_ended_queue_check
    import deq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_stall,
    input  logic [2:0]    op,
    input  logic [DW-1:0] value,
    input  logic          rsp_valid,
    input  logic          rsp_stall,
    input  logic [DW-1:0] data,
    input  logic [SW-1:0] status,
    input  logic          last,
    output int            fail_count,
    output int            pending_count,
    output int            beat_count,
    output int            full_count,
    output int            empty_count
);

    typedef struct {
        logic [DW-1:0] data;
        logic [SW-1:0] status;
        logic          last;
    } beat_t;

    // shadow deque: ring, front position, occupancy
    logic [DW-1:0] ring [DEPTH];
    int            head;
    int            fill;
    beat_t         pending_beats [$];

    int errors;
    int checked;
    int fulls;
    int empties;

    function automatic int slot(int k);
        return (head + k) % DEPTH;
    endfunction

    function automatic void queue_beat(logic [DW-1:0] d, logic [SW-1:0] s, logic l);
        beat_t b;
        b.data   = d;
        b.status = s;
        b.last   = l;
        pending_beats.push_back(b);
    endfunction

    function automatic void apply_request(logic [2:0] code, logic [DW-1:0] word);
        int pos;
        case (code)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (fill == DEPTH)
                begin
                    queue_beat('0, ST_FULL, 1'b1);
                end
                else
                begin
                    if (code == OP_PUSH_FRONT)
                    begin
                        head = (head == 0) ? DEPTH - 1 : head - 1;
                        ring[head] = word;
                    end
                    else
                    begin
                        ring[slot(fill)] = word;
                    end
                    fill++;
                    queue_beat('0, ST_OK, 1'b1);
                end
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (fill == 0)
                begin
                    queue_beat('0, ST_EMPTY, 1'b1);
                end
                else
                begin
                    if (code == OP_POP_FRONT)
                    begin
                        queue_beat(ring[head], ST_OK, 1'b1);
                        head = slot(1);
                    end
                    else
                    begin
                        queue_beat(ring[slot(fill - 1)], ST_OK, 1'b1);
                    end
                    fill--;
                end
            end
            OP_LIST_FWD, OP_LIST_BWD:
            begin
                if (fill == 0)
                begin
                    queue_beat('0, ST_EMPTY, 1'b1);
                end
                else
                begin
                    for (int k = 0; k < fill; k++)
                    begin
                        pos = (code == OP_LIST_FWD) ? slot(k) : slot(fill - 1 - k);
                        queue_beat(ring[pos], ST_OK, k == fill - 1);
                    end
                end
            end
            default:
            begin
                // spare codes: no beat, no state change
            end
        endcase
    endfunction

    function automatic void compare_beat();
        beat_t want;
        if (pending_beats.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected beat, expected none, got data %h status %0d last %0d",
                     $time, data, status, last);
            return;
        end
        want = pending_beats.pop_front();
        checked++;
        if (status == ST_FULL)
            fulls++;
        if (status == ST_EMPTY)
            empties++;
        if (data !== want.data)
        begin
            errors++;
            $display("%0t: data mismatch, expected %h, got %h", $time, want.data, data);
        end
        if (status !== want.status)
        begin
            errors++;
            $display("%0t: status mismatch, expected %0d, got %0d", $time, want.status, status);
        end
        if (last !== want.last)
        begin
            errors++;
            $display("%0t: last mismatch, expected %0d, got %0d", $time, want.last, last);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head = 0;
            fill = 0;
            pending_beats.delete();
        end
        else
        begin
            // request first, so a same-edge response still finds its beat
            if (req_valid && !req_stall)
                apply_request(op, value);
            if (rsp_valid && !rsp_stall)
                compare_beat();
        end
        fail_count    <= errors;
        pending_count <= pending_beats.size();
        beat_count    <= checked;
        full_count    <= fulls;
        empty_count   <= empties;
    end

endmodule

// ===== tb/double_ended_queue_test.sv =====
`timescale 1ns / 100ps

module double_ended_queue_test;
    import deq_pkg::*;

    localparam int QDEPTH = 16;
    localparam int REQUEST_TARGET = 310;

    // codes the block must ignore without a beat
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    logic          clk;
    logic          rst_n = 1'b0;
    logic          req_valid = 1'b0;
    logic          req_stall;
    logic [2:0]    op = '0;
    logic [DW-1:0] value = '0;
    logic          rsp_valid;
    logic          rsp_stall = 1'b1;
    logic [DW-1:0] data;
    logic [SW-1:0] status;
    logic          last;

    int fail_count;
    int pending_count;
    int beat_count;
    int full_count;
    int empty_count;

    int requests_sent;
    // when set, neither side inserts gaps or stalls
    bit steady;

    double_ended_queue #(.DEPTH(QDEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .op        (op),
        .value     (value),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .data      (data),
        .status    (status),
        .last      (last)
    );

    double_ended_queue_check #(.DEPTH(QDEPTH)) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .op            (op),
        .value         (value),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .data          (data),
        .status        (status),
        .last          (last),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .beat_count    (beat_count),
        .full_count    (full_count),
        .empty_count   (empty_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, 10);
    endfunction

    // random word, leaning on the sign and range extremes
    function automatic logic [DW-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_push();
        return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    endfunction

    function automatic logic [2:0] pick_pop();
        return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
    endfunction

    function automatic logic [2:0] pick_list();
        return $urandom_range(0, 1) ? OP_LIST_BWD : OP_LIST_FWD;
    endfunction

    // one request beat; returns after the edge that accepted it
    task automatic send_req(input logic [2:0] code, input logic [DW-1:0] word);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        op        <= code;
        value     <= word;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        if (code <= OP_LIST_BWD)
            requests_sent++;
    endtask

    // response side: random stall before each beat
    initial
    begin
        int hold;
        @(posedge rst_n);
        forever
        begin
            hold = draw_gap();
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do
                @(posedge clk);
            while (rsp_valid !== 1'b1);
        end
    end

    initial
    begin
        int kind;
        int reps;
        int r;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty cases, spare codes, extremes at both ends, both listings
        steady = 1'b0;
        send_req(OP_POP_FRONT, '0);
        send_req(OP_POP_BACK, '0);
        send_req(OP_LIST_FWD, '0);
        send_req(OP_LIST_BWD, '0);
        send_req(OP_SPARE_LO, 32'h1234_5678);
        send_req(OP_SPARE_HI, 32'hedcb_a987);
        send_req(OP_PUSH_FRONT, 32'h7fff_ffff);
        send_req(OP_PUSH_BACK, 32'h8000_0000);
        send_req(OP_PUSH_FRONT, 32'h0000_0000);
        send_req(OP_PUSH_BACK, 32'hffff_ffff);
        send_req(OP_LIST_FWD, '0);
        send_req(OP_LIST_BWD, '0);
        send_req(OP_POP_BACK, '0);
        send_req(OP_POP_FRONT, '0);
        send_req(OP_LIST_FWD, '0);

        // random phases: mixed traffic, fill past full, drain past empty
        while (requests_sent < REQUEST_TARGET)
        begin
            steady = ($urandom_range(0, 3) == 0);
            kind   = $urandom_range(0, 9);
            if (kind < 5)
            begin
                reps = $urandom_range(4, 20);
                repeat (reps)
                begin
                    r = $urandom_range(0, 31);
                    if (r == 0)
                        send_req($urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO,
                                 pick_word());
                    else if (r < 14)
                        send_req(pick_push(), pick_word());
                    else if (r < 26)
                        send_req(pick_pop(), pick_word());
                    else
                        send_req(pick_list(), pick_word());
                end
            end
            else if (kind < 8)
            begin
                // enough pushes to hit full whatever the occupancy was
                reps = QDEPTH + $urandom_range(1, 2);
                repeat (reps) send_req(pick_push(), pick_word());
                send_req(pick_list(), pick_word());
            end
            else
            begin
                reps = QDEPTH + $urandom_range(1, 2);
                repeat (reps) send_req(pick_pop(), pick_word());
            end
        end

        req_valid <= 1'b0;
        steady = 1'b0;

        do
            @(posedge clk);
        while (pending_count != 0);
        repeat (20) @(posedge clk);

        $display("covered %0d requests and %0d result beats", requests_sent, beat_count);
        $display("of those beats %0d reported full and %0d reported empty",
                 full_count, empty_count);
        if (fail_count == 0)
            $display("double_ended_queue_test passed");
        else
            $display("double_ended_queue_test failed");
        $finish;
    end

    // watchdog, well past the slowest legal run
    initial
    begin
        #4000000;
        $display("double_ended_queue_test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/deq_pkg.sv
hdl/deq_cell.sv
hdl/double_ended_queue.sv
tb/double_ended_queue_check.sv
tb/double_ended_queue_test.sv
